// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/fpalu_pkg.sv =====
`default_nettype none
package fpalu_pkg;
  localparam int FracBitsDefault = 8;
  localparam int QueueDepthDefault = 4;

  localparam logic [3:0] KIND_ADD = 4'd0;
  localparam logic [3:0] KIND_SUB = 4'd1;
  localparam logic [3:0] KIND_MUL = 4'd2;
  localparam logic [3:0] KIND_DIV = 4'd3;
  localparam logic [3:0] KIND_INC = 4'd4;
  localparam logic [3:0] KIND_DEC = 4'd5;
  localparam logic [3:0] KIND_MIN = 4'd6;
  localparam logic [3:0] KIND_MAX = 4'd7;
  localparam logic [3:0] KIND_CMP = 4'd8;
  localparam logic [3:0] KIND_FROM_INT = 4'd9;
  localparam logic [3:0] KIND_TO_INT = 4'd10;

  // Classified word handed from front to back.
  typedef struct packed {
    logic [3:0]  kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic        lt;
    logic        eq;
    logic        gt;
  } fpalu_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        ovf;
    logic        dz;
  } fpalu_res_t;
endpackage
`default_nettype wire

// ===== sv/fpalu_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module fpalu_front #(
  parameter int QueueDepth = 4
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  wire  [3:0] kind,
  input  wire  signed [31:0] operand_a,
  input  wire  signed [31:0] operand_b,
  output logic full,
  input  wire  pop,
  output logic empty,
  output fpalu_pkg::fpalu_word_t head
);
  import fpalu_pkg::*;
  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  fpalu_word_t mem [QueueDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  fpalu_word_t   wd;

  always_comb begin
    wd.kind = kind;
    wd.a    = operand_a;
    wd.b    = operand_b;
    wd.lt   = operand_a < operand_b;
    wd.eq   = operand_a == operand_b;
    wd.gt   = operand_a > operand_b;
  end

  assign full  = cnt_r == (AW+1)'(QueueDepth);
  assign empty = cnt_r == '0;
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp_r] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == AW'(QueueDepth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == AW'(QueueDepth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

  `ASSERT_IMPLY(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= (AW+1)'(QueueDepth))
  `ASSERT_NEXT(a_push_notempty, clk, rst_n, push && !full, !empty)
  `ASSERT_IMPLY(a_flags_onehot, clk, rst_n, !empty, $onehot({head.lt, head.eq, head.gt}))
endmodule
`default_nettype wire

// ===== sv/fpalu_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module fpalu_back #(
  parameter int FracBits = 8
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  fpalu_pkg::fpalu_word_t in_word,
  output logic out_valid,
  output fpalu_pkg::fpalu_res_t out_res
);
  import fpalu_pkg::*;
  localparam int NW = 32 + FracBits;        // divider numerator width
  localparam int NS = NW + 1;               // stages: NW bits plus output

  // Stage 0: decode, simple ops, multiply.
  logic        v0_r;
  fpalu_word_t w0_r;
  logic signed [31:0] simp0_r;
  logic        ovf0_r;
  logic [63:0] prod0_r;
  logic        pneg0_r;
  logic [NW-1:0] num0_r;
  logic [31:0] den0_r;
  logic        qneg0_r;

  logic signed [32:0] sadd, ssub, sinc, sdec;
  logic signed [31:0] simp;
  logic        ovf;
  logic [31:0] ma, mb;
  logic signed [63:0] fi;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'h7FFFFFFF;
    if (v < -33'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  always_comb begin
    sadd = 33'(in_word.a) + 33'(in_word.b);
    ssub = 33'(in_word.a) - 33'(in_word.b);
    sinc = 33'(in_word.a) + 33'sd1;
    sdec = 33'(in_word.a) - 33'sd1;
    fi   = 64'(in_word.a) <<< FracBits;
    ma   = in_word.a[31] ? 32'(-in_word.a) : in_word.a;
    mb   = in_word.b[31] ? 32'(-in_word.b) : in_word.b;
    simp = '0;
    ovf  = 1'b0;
    case (in_word.kind)
      KIND_ADD: begin simp = sat33(sadd); ovf = sadd[32] != sadd[31]; end
      KIND_SUB: begin simp = sat33(ssub); ovf = ssub[32] != ssub[31]; end
      KIND_INC: begin simp = sat33(sinc); ovf = sinc[32] != sinc[31]; end
      KIND_DEC: begin simp = sat33(sdec); ovf = sdec[32] != sdec[31]; end
      KIND_MIN: simp = in_word.gt ? in_word.b : in_word.a;
      KIND_MAX: simp = in_word.lt ? in_word.b : in_word.a;
      KIND_FROM_INT: begin
        if (fi > 64'sd2147483647) begin simp = 32'h7FFFFFFF; ovf = 1'b1; end
        else if (fi < -64'sd2147483648) begin simp = 32'h80000000; ovf = 1'b1; end
        else simp = fi[31:0];
      end
      KIND_TO_INT: simp = in_word.a >>> FracBits;
      default: begin simp = '0; ovf = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    w0_r    <= in_word;
    simp0_r <= simp;
    ovf0_r  <= ovf;
    prod0_r <= 64'(ma) * 64'(mb);
    pneg0_r <= in_word.a[31] ^ in_word.b[31];
    num0_r  <= {ma, FracBits'(0)};
    den0_r  <= mb;
    qneg0_r <= in_word.a[31] ^ in_word.b[31];
  end

  // Divider: one quotient bit per stage, restoring.
  typedef struct packed {
    logic        v;
    fpalu_word_t w;
    logic signed [31:0] simp;
    logic        ovf;
    logic [63:0] prod;
    logic        pneg;
    logic [NW-1:0] num;
    logic [32:0] rem;
    logic [31:0] den;
    logic        qneg;
  } stg_t;

  stg_t st_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_div
      stg_t prev, nxt;
      logic [33:0] trial;
      if (g == 0) begin : g_first
        always_comb begin
          prev.v = v0_r; prev.w = w0_r; prev.simp = simp0_r; prev.ovf = ovf0_r;
          prev.prod = prod0_r; prev.pneg = pneg0_r; prev.num = num0_r;
          prev.rem = '0; prev.den = den0_r; prev.qneg = qneg0_r;
        end
      end else begin : g_rest
        always_comb begin
          prev = st_r[g-1];
        end
      end
      always_comb begin
        nxt = prev;
        trial = '0;
        if (g < NW) begin
          trial = {prev.rem, prev.num[NW-1]} - {2'b00, prev.den};
          nxt.num = {prev.num[NW-2:0], ~trial[33]};
          nxt.rem = trial[33] ? {prev.rem[31:0], prev.num[NW-1]} : trial[32:0];
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) st_r[g].v <= 1'b0;
        else st_r[g].v <= nxt.v;
        st_r[g].w <= nxt.w; st_r[g].simp <= nxt.simp; st_r[g].ovf <= nxt.ovf;
        st_r[g].prod <= nxt.prod; st_r[g].pneg <= nxt.pneg; st_r[g].num <= nxt.num;
        st_r[g].rem <= nxt.rem; st_r[g].den <= nxt.den; st_r[g].qneg <= nxt.qneg;
      end
    end
  endgenerate

  // Final stage: rounding and saturation for mul and div, and the divide-by-zero result.
  stg_t fin;
  logic [63:0] pq;
  logic [NW:0] dq;
  logic [33:0] drem2;
  logic [64:0] mag;
  logic        neg;
  fpalu_res_t  res;

  always_comb begin
    fin   = st_r[NS-1];
    pq    = (fin.prod + (64'd1 << (FracBits - 1))) >> FracBits;
    drem2 = {fin.rem, 1'b0};
    dq    = {1'b0, fin.num} + ((drem2 >= {2'b00, fin.den}) ? (NW+1)'(1) : '0);
    mag   = '0;
    neg   = 1'b0;
    res.value = fin.simp;
    res.ovf   = fin.ovf;
    res.dz    = 1'b0;
    res.lt = fin.w.lt; res.eq = fin.w.eq; res.gt = fin.w.gt;
    case (fin.w.kind)
      KIND_MUL: begin mag = 65'(pq); neg = fin.pneg; end
      KIND_DIV: begin mag = 65'(dq); neg = fin.qneg; end
      default: begin mag = '0; neg = 1'b0; end
    endcase
    if (fin.w.kind == KIND_MUL || (fin.w.kind == KIND_DIV && fin.den != '0)) begin
      if (neg) begin
        if (mag > 65'h80000000) begin res.value = 32'h80000000; res.ovf = 1'b1; end
        else res.value = 32'(-mag);
      end else begin
        if (mag > 65'h7FFFFFFF) begin res.value = 32'h7FFFFFFF; res.ovf = 1'b1; end
        else res.value = mag[31:0];
      end
    end else if (fin.w.kind == KIND_DIV) begin
      res.dz = 1'b1;
      res.ovf = 1'b0;
      res.value = fin.w.a[31] ? 32'h80000000 : 32'h7FFFFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= fin.v;
    out_res <= res;
  end

  `ASSERT_IMPLY(a_dz_only_div, clk, rst_n, out_valid, !(out_res.dz && out_res.ovf))
  `ASSERT_NEXT(a_in_flows, clk, rst_n, in_valid, v0_r)
  `ASSERT_IMPLY(a_out_flags_onehot, clk, rst_n, out_valid, $onehot({out_res.lt, out_res.eq, out_res.gt}))
endmodule
`default_nettype wire

// ===== sv/fixed_point_alu_top.sv =====
`default_nettype none
// Fixed-point ALU, signed 32-bit raw words with FRAC_BITS fraction bits.
// Input channel: drive in_kind, in_operand_a and in_operand_b with start high;
// the word is taken on a rising edge where start is high and busy is low.
// Result channel: out_valid strobes for exactly one cycle with the result
// value and the less, equal, greater, overflow and divide-by-zero flags.
// The receiver cannot hold results off, so the back end never stalls.
// Words pass through the input queue, then the back pipeline: one decode and
// multiply stage, one divider stage per quotient bit of the 32 + FRAC_BITS bit
// numerator, one further stage, and the output register, which takes the
// rounded and saturated result.
// Throughput: one word per cycle while busy is low; every kind goes through the same pipeline.
// Busy rises only if the small queue between front and back fills; at
// QUEUE_DEPTH >= 2 it cannot, since the back end drains one word a cycle.
// Reset (rst_n low, synchronous) empties the queue and clears all valid bits;
// words in flight are dropped.
module fixed_point_alu_top #(
  parameter int FRAC_BITS = fpalu_pkg::FracBitsDefault,
  parameter int QUEUE_DEPTH = fpalu_pkg::QueueDepthDefault
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  start,
  output logic busy,
  input  wire  [3:0] in_kind,
  input  wire  signed [31:0] in_operand_a,
  input  wire  signed [31:0] in_operand_b,
  output logic out_valid,
  output logic signed [31:0] out_result_value,
  output logic out_less_flag,
  output logic out_equal_flag,
  output logic out_greater_flag,
  output logic out_overflow_flag,
  output logic out_divide_by_zero_flag
);
  import fpalu_pkg::*;

  logic        q_full, q_empty;
  fpalu_word_t q_head;
  fpalu_res_t  res;

  // Accept while the queue has room.
  assign busy = q_full;

  fpalu_front #(.QueueDepth(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .push(start), .kind(in_kind), .operand_a(in_operand_a), .operand_b(in_operand_b),
    .full(q_full), .pop(!q_empty), .empty(q_empty), .head(q_head)
  );

  // Advance one word a cycle into the back pipeline.
  fpalu_back #(.FracBits(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(!q_empty), .in_word(q_head),
    .out_valid(out_valid), .out_res(res)
  );

  assign out_result_value        = res.value;
  assign out_less_flag           = res.lt;
  assign out_equal_flag          = res.eq;
  assign out_greater_flag        = res.gt;
  assign out_overflow_flag       = res.ovf;
  assign out_divide_by_zero_flag = res.dz;
endmodule
`default_nettype wire
